// ----- src/segu_pkg.sv -----
// Shared types and constants for the spring energy gradient unit.
package segu_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned NodeW  = 16;
    localparam int unsigned EnW    = 63;
    localparam logic [EnW-1:0] Sat63 = {EnW{1'b1}};

    typedef struct packed {
        logic [NodeW-1:0]  node_a;
        logic [NodeW-1:0]  node_b;
        logic [CoordW-1:0] pos_a_x;
        logic [CoordW-1:0] pos_a_y;
        logic [CoordW-1:0] pos_a_z;
        logic [CoordW-1:0] pos_b_x;
        logic [CoordW-1:0] pos_b_y;
        logic [CoordW-1:0] pos_b_z;
        logic [CoordW-1:0] rest_len;
        logic              last_edge;
    } edge_in_t;

    typedef struct packed {
        logic [NodeW-1:0]  edge_a;
        logic [NodeW-1:0]  edge_b;
        logic [CoordW-1:0] grad_x;
        logic [CoordW-1:0] grad_y;
        logic [CoordW-1:0] grad_z;
        logic [EnW-1:0]    energy_term;
        logic [EnW-1:0]    energy_total;
        logic              zero_length;
        logic              last_out;
    } edge_out_t;

    // Request and response between sequencer and shared divide/sqrt unit.
    typedef struct packed {
        logic         start;
        logic         is_sqrt;
        logic [127:0] num;
        logic [63:0]  den;
    } dsu_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] result;
    } dsu_rsp_t;

endpackage

// ----- src/segu_if.sv -----
// Valid/ready channel interface carrying one payload beat.
interface segu_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/segu_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module segu_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);
    logic [127:0] acc_reg, acc_next;
    logic [127:0] mcand_reg, mcand_next;
    logic [63:0]  mplier_reg, mplier_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    // Add the shifted multiplicand while multiplier bits remain.
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[126:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[63:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

// ----- src/segu_dsu.sv -----
// Shared restoring divide / square-root unit, one result bit per cycle.
module segu_dsu (
    input  logic                clk,
    input  logic                rst_n,
    input  segu_pkg::dsu_req_t  req,
    output segu_pkg::dsu_rsp_t  rsp
);
    import segu_pkg::*;

    logic [127:0] num_reg, num_next;
    logic [127:0] quo_reg, quo_next;
    logic [65:0]  rem_reg, rem_next;
    logic [63:0]  den_reg, den_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         sqrt_reg, sqrt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [65:0]  trial;
    logic [65:0]  cand;
    logic [65:0]  rsh;

    // Divide: shift one dividend bit into the remainder, subtract divisor.
    // Sqrt: shift two radicand bits, subtract 4*root+1.
    // Radicand is below 2^70, so 35 digit pairs give the full root.
    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        cand      = '0;
        rsh       = '0;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
            rem_next  = '0;
            sqrt_next = req.is_sqrt;
            cnt_next  = req.is_sqrt ? 7'd34 : 7'd127;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                rsh  = {rem_reg[63:0], num_reg[69:68]};
                cand = {quo_reg[63:0], 2'b01};
                num_next = {num_reg[125:0], 2'b00};
                if (rsh >= cand)
                begin
                    rem_next = rsh - cand;
                    quo_next = {quo_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    quo_next = {quo_reg[126:0], 1'b0};
                end
            end
            else
            begin
                trial    = {rem_reg[64:0], num_reg[127]};
                num_next = {num_reg[126:0], 1'b0};
                if (trial >= {2'b00, den_reg})
                begin
                    rem_next = trial - {2'b00, den_reg};
                    quo_next = {quo_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[126:0], 1'b0};
                end
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
        sqrt_reg <= sqrt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;
endmodule

// ----- src/spring_energy_gradient_unit_top.sv -----
// Spring energy gradient unit: edge sequencer, serial multiplier, divide/sqrt.
//
// Each edge is processed alone: the squared length is built by a bit-serial
// multiplier, its square root and the three gradient divisions share one
// restoring divide/sqrt unit that retires one bit per cycle (35 bits for
// the root, 128 per division). An edge is shortest at zero length and zero
// rest length, when no gradient division runs, and longest when all three
// gradient divisions run with full-width operands. One result beat per
// edge; the output register holds it until taken while no new edge is
// accepted. The energy total saturates at 2^63-1 and clears after an
// edge marked last.
module spring_energy_gradient_unit_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    segu_if.sink        in_ch,
    segu_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import segu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQW, ST_SQRT, ST_DD, ST_KD,
        ST_GM, ST_GD, ST_EN, ST_OUT
    } state_t;

    localparam logic [1:0] RegStiff = 2'd0;

    state_t       state_reg, state_next;
    logic [31:0]  k_reg;
    logic [EnW-1:0] acc_reg, acc_next;
    edge_in_t     in_reg;
    edge_out_t    out_reg, out_next;
    logic         ovld_reg, ovld_next;
    logic [1:0]   ax_reg, ax_next;
    logic [127:0] sum_reg, sum_next;
    logic [63:0]  n_reg, n_next;
    logic [33:0]  dm_reg, dm_next;
    logic         dneg_reg, dneg_next;
    logic [127:0] kd_reg, kd_next;
    logic         t_reg, t_next;
    logic         mstart;
    logic [127:0] ma;
    logic [63:0]  mb;
    logic         mdone;
    logic [127:0] mprod;
    dsu_req_t     dreq;
    dsu_rsp_t     drsp;
    logic signed [32:0] ecomp;
    logic [32:0]  emag;
    logic [127:0] esh;
    logic [127:0] q;
    logic [31:0]  g;
    logic         gneg;
    logic [EnW:0] tot;
    logic [EnW-1:0] term;

    segu_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                    .done(mdone), .prod(mprod));
    segu_dsu u_dsu (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Config register
    assign pready = 1'b1;
    assign prdata = (paddr == RegStiff) ? k_reg : '0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= 32'(1) << FRAC_BITS;
        else if (psel && penable && pwrite && paddr == RegStiff)
            k_reg <= pwdata;
    end

    // Component of e selected by axis counter.
    always_comb
    begin
        case (ax_reg)
            2'd0:    ecomp = 33'(signed'(in_reg.pos_b_x)) - 33'(signed'(in_reg.pos_a_x));
            2'd1:    ecomp = 33'(signed'(in_reg.pos_b_y)) - 33'(signed'(in_reg.pos_a_y));
            default: ecomp = 33'(signed'(in_reg.pos_b_z)) - 33'(signed'(in_reg.pos_a_z));
        endcase
        emag = ecomp[32] ? 33'(-ecomp) : 33'(ecomp);
    end

    assign in_ch.ready  = (state_reg == ST_IDLE) && !ovld_reg;
    assign out_ch.valid = ovld_reg;
    assign out_ch.data  = out_reg;

    // Edge sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        out_next   = out_reg;
        ovld_next  = ovld_reg;
        ax_next    = ax_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        dm_next    = dm_reg;
        dneg_next  = dneg_reg;
        kd_next    = kd_reg;
        t_next     = t_reg;
        mstart     = 1'b0;
        ma         = '0;
        mb         = '0;
        dreq       = '0;
        esh        = '0;
        q          = drsp.result;
        g          = '0;
        gneg       = 1'b0;
        tot        = '0;
        term       = '0;
        if (ovld_reg && out_ch.ready)
            ovld_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && !ovld_reg)
                begin
                    ax_next    = '0;
                    sum_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                mstart     = 1'b1;
                ma         = 128'(emag);
                mb         = 64'(emag);
                state_next = ST_SQW;
            end
            ST_SQW:
            begin
                if (mdone)
                begin
                    sum_next = sum_reg + mprod;
                    if (ax_reg == 2'd2)
                    begin
                        dreq.start   = 1'b1;
                        dreq.is_sqrt = 1'b1;
                        dreq.num     = sum_reg + mprod;
                        state_next   = ST_SQRT;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQRT:
            begin
                if (drsp.done)
                begin
                    n_next = drsp.result[63:0];
                    if (drsp.result[63:0] >= 64'(in_reg.rest_len))
                    begin
                        dm_next   = 34'(drsp.result[63:0] - 64'(in_reg.rest_len));
                        dneg_next = 1'b0;
                    end
                    else
                    begin
                        dm_next   = 34'(64'(in_reg.rest_len) - drsp.result[63:0]);
                        dneg_next = 1'b1;
                    end
                    state_next = ST_DD;
                end
            end
            ST_DD:
            begin
                if (!mstart && !mdone && t_reg == 1'b0)
                begin
                    mstart = 1'b1;
                    ma     = 128'(dm_reg);
                    mb     = 64'(dm_reg);
                    t_next = 1'b1;
                end
                else if (mdone)
                begin
                    mstart     = 1'b1;
                    ma         = mprod;
                    mb         = 64'(k_reg);
                    t_next     = 1'b0;
                    state_next = ST_EN;
                end
            end
            ST_EN:
            begin
                if (mdone)
                begin
                    esh  = mprod >> (FRAC_BITS + 1);
                    term = (esh[127:EnW] != '0) ? Sat63 : esh[EnW-1:0];
                    tot  = {1'b0, acc_reg} + {1'b0, term};
                    out_next.energy_term  = term;
                    out_next.energy_total = tot[EnW] ? Sat63 : tot[EnW-1:0];
                    acc_next = in_reg.last_edge ? '0 :
                               (tot[EnW] ? Sat63 : tot[EnW-1:0]);
                    out_next.edge_a      = in_reg.node_a;
                    out_next.edge_b      = in_reg.node_b;
                    out_next.zero_length = (n_reg == '0);
                    out_next.last_out    = in_reg.last_edge;
                    out_next.grad_x      = '0;
                    out_next.grad_y      = '0;
                    out_next.grad_z      = '0;
                    ax_next = '0;
                    mstart  = 1'b1;
                    ma      = 128'(k_reg);
                    mb      = 64'(dm_reg);
                    state_next = ST_KD;
                end
            end
            ST_KD:
            begin
                if (mdone)
                begin
                    kd_next    = mprod;
                    state_next = ST_GM;
                end
            end
            ST_GM:
            begin
                if (n_reg == '0 || dm_reg == '0 || emag == '0)
                begin
                    if (ax_reg == 2'd2)
                    begin
                        ovld_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        ax_next = ax_reg + 2'd1;
                end
                else if (!mdone && t_reg == 1'b0)
                begin
                    mstart = 1'b1;
                    ma     = kd_reg;
                    mb     = 64'(emag);
                    t_next = 1'b1;
                end
                else if (mdone)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = mprod;
                    dreq.den   = n_reg << FRAC_BITS;
                    t_next     = 1'b0;
                    state_next = ST_GD;
                end
            end
            ST_GD:
            begin
                if (drsp.done)
                begin
                    gneg = dneg_reg == ecomp[32];
                    if (gneg)
                        g = (q[127:31] != '0) ? 32'h8000_0000 : 32'(-q[31:0]);
                    else
                        g = (q[127:31] != '0) ? 32'h7FFF_FFFF : q[31:0];
                    case (ax_reg)
                        2'd0:    out_next.grad_x = g;
                        2'd1:    out_next.grad_y = g;
                        default: out_next.grad_z = g;
                    endcase
                    if (ax_reg == 2'd2)
                    begin
                        ovld_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = ST_GM;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            ovld_reg  <= 1'b0;
            t_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ovld_reg  <= ovld_next;
            t_reg     <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_reg <= in_ch.data;
        out_reg  <= out_next;
        ax_reg   <= ax_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        dm_reg   <= dm_next;
        dneg_reg <= dneg_next;
        kd_reg   <= kd_next;
    end
endmodule

// ----- bench/spring_energy_gradient_unit_top_tb.sv -----
// Testbench for the spring energy gradient unit: directed and random edges, scoreboard check.
`timescale 1ns / 100ps

module spring_energy_gradient_unit_top_tb;
    import segu_pkg::*;

    localparam int unsigned FracBits = 16;
    localparam int unsigned CycleLimit = 2000000;
    localparam logic [1:0] AddrStiffness = 2'd0;
    localparam logic [62:0] EnMax = 63'h7FFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    segu_if #(.payload_t(edge_in_t)) in_ch ();
    segu_if #(.payload_t(edge_out_t)) out_ch ();

    spring_energy_gradient_unit_top #(.FRAC_BITS(FracBits)) u_top (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // Model state
    logic [31:0] stiff_model;
    logic [62:0] energy_sum_model;

    edge_in_t edge_queue[$];
    edge_out_t expected_grads[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit hold_feed = 1'b0;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Append one edge to the pending queue
    function automatic void add_edge(edge_in_t it);
        edge_queue.insert(edge_queue.size(), it);
    endfunction

    // Expected result of one edge; updates the running energy sum
    function automatic edge_out_t predict_edge(edge_in_t it);
        edge_out_t r;
        logic signed [33:0] e[3];
        logic [33:0] em[3];
        logic [127:0] sq_sum, cand_sq, num, q;
        logic [63:0] root, cand, dm;
        logic signed [64:0] d;
        logic [127:0] w;
        logic [62:0] term;
        logic [63:0] total;
        logic signed [31:0] pa[3], pb[3];
        bit neg;
        pa[0] = it.pos_a_x; pa[1] = it.pos_a_y; pa[2] = it.pos_a_z;
        pb[0] = it.pos_b_x; pb[1] = it.pos_b_y; pb[2] = it.pos_b_z;
        sq_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = 34'(pb[i]) - 34'(pa[i]);
            em[i] = e[i][33] ? 34'(-e[i]) : 34'(e[i]);
            sq_sum += 128'(em[i]) * 128'(em[i]);
        end
        root = '0;
        for (int b = 34; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            cand_sq = 128'(cand) * 128'(cand);
            if (cand_sq <= sq_sum) root = cand;
        end
        d = 65'(root) - 65'(it.rest_len);
        dm = d[64] ? 64'(-d) : 64'(d);
        w = (128'(dm) * 128'(dm) * 128'(stiff_model)) >> (FracBits + 1);
        term = (w > 128'(EnMax)) ? EnMax : w[62:0];
        total = 64'(energy_sum_model) + 64'(term);
        if (total > 64'(EnMax)) total = 64'(EnMax);
        r = '0;
        r.edge_a = it.node_a;
        r.edge_b = it.node_b;
        for (int i = 0; i < 3; i++)
        begin
            logic [31:0] g;
            g = '0;
            if (root != 0 && d != 0 && e[i] != 0)
            begin
                neg = d[64] == e[i][33];
                num = 128'(stiff_model) * 128'(dm) * 128'(em[i]);
                q = num / (128'(root) << FracBits);
                if (neg)
                    g = (q >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
                else
                    g = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            end
            if (i == 0) r.grad_x = g;
            else if (i == 1) r.grad_y = g;
            else r.grad_z = g;
        end
        r.energy_term = term;
        r.energy_total = total[62:0];
        r.zero_length = (root == 0);
        r.last_out = it.last_edge;
        energy_sum_model = it.last_edge ? '0 : total[62:0];
        return r;
    endfunction

    // Source side: one beat from the queue after a random gap
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_grads.insert(expected_grads.size(), predict_edge(in_ch.data));
                send_gap = $urandom_range(19);
                if (edge_queue.size() > 0 && send_gap == 0 && !hold_feed)
                    in_ch.data <= edge_queue.pop_front();
                else
                    in_ch.valid <= 1'b0;
            end
            else if (!in_ch.valid && !hold_feed && edge_queue.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= edge_queue.pop_front();
                end
            end
        end
    end

    // Sink side: random stall before each beat, then compare
    int recv_gap = 0;
    always @(posedge clk)
    begin
        edge_out_t exp_r;
        cycle_count++;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_grads.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat %p", out_ch.data);
                end
                else
                begin
                    exp_r = expected_grads.pop_front();
                    if (out_ch.data !== exp_r)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, out_ch.data);
                    end
                end
                recv_gap = $urandom_range(19);
                if ($urandom_range(3) == 0) recv_gap = 0;
                out_ch.ready <= (recv_gap == 0);
            end
            else if (!out_ch.ready)
            begin
                if (recv_gap > 0) recv_gap--;
                else out_ch.ready <= 1'b1;
            end
        end
        if (cycle_count > CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_write(input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrStiffness; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        stiff_model = val;
    endtask

    task automatic wait_drained();
        while (edge_queue.size() > 0 || in_ch.valid || expected_grads.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
            default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        endcase
    endfunction

    function automatic edge_in_t rand_edge(bit last);
        edge_in_t it;
        int mode;
        mode = $urandom_range(5);
        it.node_a = $urandom();
        it.node_b = $urandom();
        it.pos_a_x = rand_coord(mode);
        it.pos_a_y = rand_coord(mode);
        it.pos_a_z = rand_coord(mode);
        if ($urandom_range(15) == 0)
        begin
            it.pos_b_x = it.pos_a_x; it.pos_b_y = it.pos_a_y; it.pos_b_z = it.pos_a_z;
        end
        else
        begin
            it.pos_b_x = it.pos_a_x + rand_coord(mode);
            it.pos_b_y = it.pos_a_y + rand_coord(mode);
            it.pos_b_z = it.pos_a_z + rand_coord(mode);
        end
        it.rest_len = (mode == 0) ? $urandom() : $urandom_range(0, 150 << 16);
        it.last_edge = last;
        return it;
    endfunction

    function automatic edge_in_t mk_edge(logic [31:0] ax, ay, az, bx, by, bz, rl, bit last);
        edge_in_t it;
        it.node_a = $urandom(); it.node_b = $urandom();
        it.pos_a_x = ax; it.pos_a_y = ay; it.pos_a_z = az;
        it.pos_b_x = bx; it.pos_b_y = by; it.pos_b_z = bz;
        it.rest_len = rl; it.last_edge = last;
        return it;
    endfunction

    // Stimulus sequence
    initial
    begin
        logic [31:0] stiff_set[4];
        stiff_model = 32'h0001_0000;
        energy_sum_model = '0;
        stiff_set[0] = 32'hFFFF_FFFF;
        stiff_set[1] = 32'h0;
        stiff_set[2] = 32'h0003_8000;
        stiff_set[3] = 32'h0001_0000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed edges at reset stiffness
        add_edge(mk_edge(0, 0, 0, 0, 0, 0, 0, 0));
        add_edge(mk_edge(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        add_edge(mk_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        add_edge(mk_edge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0));
        add_edge(mk_edge(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0,
            32'h0005_0000, 0));
        add_edge(mk_edge(0, 0, 0, 32'h0003_0000, 0, 0, 32'h0001_0000, 0));
        add_edge(mk_edge(0, 0, 0, 32'hFFFD_0000, 0, 0, 32'h0009_0000, 1));
        add_edge(mk_edge(32'h1234, 1, 32'hFFFF_FFFF, 32'h1234, 1,
            32'hFFFF_FFFF, 32'h0002_0000, 1));
        wait_drained();

        // Random sets at several stiffness values
        for (int s = 0; s < 4; s++)
        begin
            apb_write(stiff_set[s]);
            for (int j = 0; j < 165; j++)
                add_edge(rand_edge(($urandom_range(7) == 0) || j == 164));
            // hold the sender until the block is empty once per phase
            while (edge_queue.size() > 80) @(posedge clk);
            hold_feed = 1'b1;
            while (in_ch.valid || expected_grads.size() > 0) @(posedge clk);
            hold_feed = 1'b0;
            wait_drained();
        end
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && expected_grads.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
